// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file tei_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tei_pkg.sv =====
// Types, codes and defaults for the tree ensemble inference unit.
package tei_pkg;

    localparam int TREES_DEF          = 256;
    localparam int NODES_PER_TREE_DEF = 64;
    localparam int FEATURES_DEF       = 256;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [1:0] KIND_NODE = 2'd0;
    localparam logic [1:0] KIND_FEAT = 2'd1;
    localparam logic [1:0] KIND_EVAL = 2'd2;

    localparam logic [1:0] REG_GLOBAL_MEAN   = 2'd0;
    localparam logic [1:0] REG_LEARNING_RATE = 2'd1;
    localparam logic [1:0] REG_TREE_COUNT    = 2'd2;

    localparam logic [31:0] GLOBAL_MEAN_RST   = 32'd0;
    localparam logic [15:0] LEARNING_RATE_RST = 16'd655;
    localparam logic [8:0]  TREE_COUNT_RST    = 9'd0;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         tree_number;
        logic [5:0]         node_number;
        logic [7:0]         feature_number;
        logic signed [31:0] value;
        logic [5:0]         low_child;
        logic [5:0]         high_child;
        logic               is_leaf;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] prediction;
        logic               walk_fault;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] global_mean;
        logic [15:0]        learning_rate;
        logic [8:0]         tree_count;
    } t_cfg;

    typedef struct packed {
        logic [7:0]         feature;
        logic signed [31:0] value;
        logic [5:0]         low;
        logic [5:0]         high;
        logic               leaf;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef enum logic [1:0] {
        OP_NODE = 2'd0,
        OP_FEAT = 2'd1,
        OP_EVAL = 2'd2
    } t_op;

    typedef struct packed {
        t_op      op;
        t_in_item item;
    } t_cmd;

endpackage

// ===== rtl/tree_ensemble_inference_unit.sv =====
// Top level of the boosted tree ensemble inference unit.
//
// Input channel: push/full queue of items that write a tree node, write a
// feature value or request an evaluation. Node and feature writes produce
// no result; an evaluation produces one result (prediction, walk_fault).
// Result channel: empty/pop queue; the oldest result sits on o_result while
// empty is low and leaves on a pop. A four-entry command queue separates
// input acceptance from execution, so items keep being taken while a
// finished result waits and the walker stalls on an unpopped result.
// Configuration: cfg channel, always ready, one register per transfer.
// Write it only while the unit is idle.
// Execution: a node or feature write is done as the idle executer takes it.
// An evaluation walks each tree from node 0; a walk that ends in a leaf adds
// the leaf value times the learning rate to the sum, while a walk out of moves
// or a child out of range sets walk_fault instead. One node-RAM read, one
// feature-RAM read and one compare per step, a node at a time.
// Reset clears the queues, the walker and the result-valid flag, and loads
// the configuration defaults; node and feature stores are not cleared and
// must be written before they are used.
module tree_ensemble_inference_unit #(
    parameter int TREES          = tei_pkg::TREES_DEF,
    parameter int NODES_PER_TREE = tei_pkg::NODES_PER_TREE_DEF,
    parameter int FEATURES       = tei_pkg::FEATURES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tei_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output tei_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import tei_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.global_mean   <= GLOBAL_MEAN_RST;
            r_cfg.learning_rate <= LEARNING_RATE_RST;
            r_cfg.tree_count    <= TREE_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GLOBAL_MEAN:   r_cfg.global_mean   <= i_cfg_data;
                REG_LEARNING_RATE: r_cfg.learning_rate <= i_cfg_data[15:0];
                REG_TREE_COUNT:    r_cfg.tree_count    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    tei_front #(
        .TREES         (TREES),
        .NODES_PER_TREE(NODES_PER_TREE),
        .FEATURES      (FEATURES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_take (cmd_take)
    );

    tei_back #(
        .TREES         (TREES),
        .NODES_PER_TREE(NODES_PER_TREE),
        .FEATURES      (FEATURES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_take (cmd_take),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

endmodule

// ===== rtl/tei_ram.sv =====
// Generic simple dual-port RAM with registered read.
module tei_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tei_front.sv =====
// Input side: accepts items, drops ignored ones and queues commands.
module tei_front #(
    parameter int TREES          = tei_pkg::TREES_DEF,
    parameter int NODES_PER_TREE = tei_pkg::NODES_PER_TREE_DEF,
    parameter int FEATURES       = tei_pkg::FEATURES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tei_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_cmd_valid,
    output tei_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_take
);
    import tei_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [QW-1:0] r_wp, n_wp;
    logic [QW-1:0] r_rp, n_rp;
    logic [QW:0]   r_cnt, n_cnt;
    logic          keep;
    t_op           op;
    logic          wr;
    logic          rd;

    always_comb begin
        keep = 1'b0;
        op   = OP_EVAL;
        unique case (i_item.kind)
            KIND_NODE: begin
                op   = OP_NODE;
                keep = (32'(i_item.tree_number) < 32'(TREES)) &&
                       (32'(i_item.node_number) < 32'(NODES_PER_TREE));
            end
            KIND_FEAT: begin
                op   = OP_FEAT;
                keep = 32'(i_item.feature_number) < 32'(FEATURES);
            end
            KIND_EVAL: begin
                op   = OP_EVAL;
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_full      = (r_cnt == (QW+1)'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = i_push && !o_full && keep;
    assign rd          = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_wp  = wr ? r_wp + 1'b1 : r_wp;
        n_rp  = rd ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (QW+1)'(wr) - (QW+1)'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= '{op: op, item: i_item};
        end
    end

endmodule

// ===== rtl/tei_back.sv =====
// Execution side: node and feature stores, tree walker, result register.
module tei_back #(
    parameter int TREES          = tei_pkg::TREES_DEF,
    parameter int NODES_PER_TREE = tei_pkg::NODES_PER_TREE_DEF,
    parameter int FEATURES       = tei_pkg::FEATURES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tei_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_valid,
    input  tei_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    input  logic               i_pop,
    output logic               o_empty,
    output tei_pkg::t_out_item o_result
);
    import tei_pkg::*;

    localparam int NA_W  = (TREES * NODES_PER_TREE > 1) ?
                           $clog2(TREES * NODES_PER_TREE) : 1;
    localparam int FA_W  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int CUR_W = $clog2(NODES_PER_TREE);
    localparam int MV_W  = $clog2(NODES_PER_TREE + 1);
    localparam int CNT_W = $clog2(TREES + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_TREE = 8'b0000_0010,
        S_NODE = 8'b0000_0100,
        S_LOOK = 8'b0000_1000,
        S_CMP  = 8'b0001_0000,
        S_ADD  = 8'b0010_0000,
        S_NEXT = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [NA_W-1:0]    r_base, n_base;
    logic [CUR_W-1:0]   r_cur, n_cur;
    logic [MV_W-1:0]    r_moves, n_moves;
    logic [CNT_W-1:0]   r_left, n_left;
    logic signed [31:0] r_thr, n_thr;
    logic [5:0]         r_lo, n_lo;
    logic [5:0]         r_hi, n_hi;
    logic               r_fvalid, n_fvalid;
    logic signed [48:0] r_prod, n_prod;
    logic [47:0]        r_sum, n_sum;
    logic               r_fault, n_fault;
    t_out_item          r_res, n_res;
    logic               r_res_valid, n_res_valid;

    logic               node_we;
    logic [NA_W-1:0]    node_waddr;
    t_node              node_wdata;
    logic [NA_W-1:0]    node_raddr;
    logic [NODE_W-1:0]  node_rdata;
    t_node              node_rd;
    logic               feat_we;
    logic [FA_W-1:0]    feat_waddr;
    logic [FA_W-1:0]    feat_raddr;
    logic signed [31:0] feat_rdata;
    logic signed [31:0] feat_val;
    logic [5:0]         nxt;
    logic signed [16:0] lr_s;
    logic               pop_ok;
    logic               load;

    tei_ram #(
        .WIDTH(NODE_W),
        .DEPTH(TREES * NODES_PER_TREE),
        .AW   (NA_W)
    ) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (node_we),
        .i_waddr(node_waddr),
        .i_wdata(node_wdata),
        .i_raddr(node_raddr),
        .o_rdata(node_rdata)
    );

    tei_ram #(
        .WIDTH(32),
        .DEPTH(FEATURES),
        .AW   (FA_W)
    ) u_feat_ram (
        .i_clk  (i_clk),
        .i_we   (feat_we),
        .i_waddr(feat_waddr),
        .i_wdata(i_cmd.item.value),
        .i_raddr(feat_raddr),
        .o_rdata(feat_rdata)
    );

    assign node_rd    = t_node'(node_rdata);
    assign node_raddr = r_base + NA_W'(r_cur);
    assign feat_raddr = FA_W'(node_rd.feature);
    assign node_waddr = NA_W'(32'(i_cmd.item.tree_number) * 32'(NODES_PER_TREE) +
                              32'(i_cmd.item.node_number));
    assign feat_waddr = FA_W'(i_cmd.item.feature_number);
    assign feat_val   = r_fvalid ? feat_rdata : 32'sd0;
    assign nxt        = (feat_val <= r_thr) ? r_lo : r_hi;
    assign lr_s       = $signed({1'b0, i_cfg.learning_rate});
    assign pop_ok     = i_pop && r_res_valid;

    always_comb begin
        node_wdata.feature = i_cmd.item.feature_number;
        node_wdata.value   = i_cmd.item.value;
        node_wdata.low     = i_cmd.item.low_child;
        node_wdata.high    = i_cmd.item.high_child;
        node_wdata.leaf    = i_cmd.item.is_leaf;
    end

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_cur      = r_cur;
        n_moves    = r_moves;
        n_left     = r_left;
        n_thr      = r_thr;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_fvalid   = r_fvalid;
        n_prod     = r_prod;
        n_sum      = r_sum;
        n_fault    = r_fault;
        n_res      = r_res;
        o_cmd_take = 1'b0;
        node_we    = 1'b0;
        feat_we    = 1'b0;
        load       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    unique case (i_cmd.op)
                        OP_NODE: node_we = 1'b1;
                        OP_FEAT: feat_we = 1'b1;
                        OP_EVAL: begin
                            n_sum   = {{16{i_cfg.global_mean[31]}}, i_cfg.global_mean};
                            n_fault = 1'b0;
                            n_base  = '0;
                            n_left  = (32'(i_cfg.tree_count) > 32'(TREES)) ?
                                      CNT_W'(TREES) : CNT_W'(i_cfg.tree_count);
                            n_state = S_TREE;
                        end
                        default: ;
                    endcase
                end
            end
            S_TREE: begin
                if (r_left == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cur   = '0;
                    n_moves = '0;
                    n_state = S_NODE;
                end
            end
            S_NODE: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (node_rd.leaf) begin
                    n_prod  = $signed(node_rd.value) * lr_s;
                    n_state = S_ADD;
                end else if (32'(r_moves) >= 32'(NODES_PER_TREE)) begin
                    n_fault = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    n_thr    = node_rd.value;
                    n_lo     = node_rd.low;
                    n_hi     = node_rd.high;
                    n_fvalid = 32'(node_rd.feature) < 32'(FEATURES);
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                if (32'(nxt) >= 32'(NODES_PER_TREE)) begin
                    n_fault = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    n_cur   = CUR_W'(nxt);
                    n_moves = r_moves + 1'b1;
                    n_state = S_NODE;
                end
            end
            S_ADD: begin
                n_sum   = r_sum + 48'(r_prod >>> 16);
                n_state = S_NEXT;
            end
            S_NEXT: begin
                n_left  = r_left - 1'b1;
                n_base  = r_base + NA_W'(NODES_PER_TREE);
                n_state = S_TREE;
            end
            S_DONE: begin
                if (!r_res_valid || i_pop) begin
                    load                = 1'b1;
                    n_res.prediction    = r_sum;
                    n_res.walk_fault    = r_fault;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_res_valid = load || (r_res_valid && !pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_cur    <= n_cur;
        r_moves  <= n_moves;
        r_left   <= n_left;
        r_thr    <= n_thr;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_fvalid <= n_fvalid;
        r_prod   <= n_prod;
        r_sum    <= n_sum;
        r_fault  <= n_fault;
        r_res    <= n_res;
    end

    assign o_empty  = !r_res_valid;
    assign o_result = r_res;

endmodule

// ===== rtl/tei_checker.sv =====
// Port-level checks for the inference unit, bound to the top level.
`include "assert_macros.svh"

module tei_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input tei_pkg::t_in_item  i_item,
    input logic               empty,
    input logic               pop,
    input tei_pkg::t_out_item o_result
);
    import tei_pkg::*;

    logic [7:0] r_pending, n_pending;
    logic       eval_in;
    logic       res_out;

    assign eval_in = push && !full && (i_item.kind == KIND_EVAL);
    assign res_out = pop && !empty;

    always_comb begin
        n_pending = r_pending + 8'(eval_in) - 8'(res_out);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `CHK_NEXT(a_res_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_result), "result changed while stalled")
    `CHK_SAME(a_res_owed, i_clk, i_rst_n, !empty, r_pending != 8'd0, "result without an evaluation")
    `CHK_NEXT(a_res_drain, i_clk, i_rst_n, res_out && r_pending == 8'd1 && !eval_in, empty, "result repeated after last transfer")
    `CHK_NEXT(a_res_latency, i_clk, i_rst_n, empty && eval_in && r_pending == 8'd0, empty, "result appeared one cycle after request")

endmodule

bind tree_ensemble_inference_unit tei_checker u_tei_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .i_item  (i_item),
    .empty   (empty),
    .pop     (pop),
    .o_result(o_result)
);
